### src/rhsv_pkg.sv
// ----------------------------------------------------------------------------
// rhsv_pkg
// Shared types, widths and the reciprocal table for the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rhsv_pkg;

    localparam int CHAN_W   = 8;            // one color channel
    localparam int HUE_W    = 9;            // hue in degrees, 0..359
    localparam int DIVD_W   = 18;           // rounded-division dividend 2N+D
    localparam int DIVS_W   = CHAN_W + 1;   // rounded-division divisor 2D
    localparam int RECIP_W  = 18;           // floor(2^17 / D)
    localparam int FRAC_W   = 18;           // reciprocal scale 2^18 over 2D
    localparam int QUOT_W   = 9;            // quotient, at most 360
    localparam int HUE_ACC_W = DIVD_W + 2;  // signed hue dividend accumulator

    localparam logic [HUE_W-1:0] HUE_WRAP = HUE_W'(360);
    localparam int TBL_DEPTH = 1 << CHAN_W;

    // Sector of the hexcone; red with green below blue wraps around 360.
    typedef enum logic [1:0] {
        SEC_RED_POS,
        SEC_GREEN,
        SEC_BLUE,
        SEC_RED_NEG
    } sector_t;

    typedef struct packed {
        logic en_a;   // lookup stage
        logic en_b;   // multiply stage
        logic en_c;   // correction stage
    } div_ctrl_t;

    typedef logic [TBL_DEPTH-1:0][RECIP_W-1:0] recip_tbl_t;

    // Elaboration-time shift-subtract build of floor(2^17 / d); entry 0 is unused.
    function automatic recip_tbl_t build_recip();
        recip_tbl_t           tbl;
        logic [RECIP_W-1:0]   q;
        logic [RECIP_W:0]     rem;
        tbl = '0;
        for (int d = 1; d < TBL_DEPTH; d++) begin
            q   = '0;
            rem = '0;
            for (int i = RECIP_W - 1; i >= 0; i--) begin
                rem = {rem[RECIP_W-1:0], (i == RECIP_W - 1)};
                if (rem >= (RECIP_W + 1)'(d)) begin
                    rem  = rem - (RECIP_W + 1)'(d);
                    q[i] = 1'b1;
                end
            end
            tbl[d] = q;
        end
        return tbl;
    endfunction

    localparam recip_tbl_t RECIP_TBL = build_recip();

endpackage

### src/rhsv_sector.sv
// ----------------------------------------------------------------------------
// rhsv_sector
// First stage: max, min, chroma and sector; forms both division dividends.
// ----------------------------------------------------------------------------
module rhsv_sector
    import rhsv_pkg::*;
(
    input  logic                 aclk,
    input  logic                 en,
    input  logic [CHAN_W-1:0]    blue,
    input  logic [CHAN_W-1:0]    green,
    input  logic [CHAN_W-1:0]    red,
    output logic [CHAN_W-1:0]    hi,
    output logic [CHAN_W-1:0]    chroma,
    output logic [DIVD_W-1:0]    hue_x,
    output logic [DIVD_W-1:0]    sat_x
);

    logic [CHAN_W-1:0]        hi_next, lo_next;
    logic signed [CHAN_W:0]   diff_next;
    sector_t                  sec_next;

    logic [CHAN_W-1:0]        hi_reg, d_reg;
    logic signed [CHAN_W:0]   diff_reg;
    sector_t                  sec_reg;

    logic [DIVD_W-1:0]        base;
    logic signed [HUE_ACC_W-1:0] diff_w, hue_acc;

    always_comb begin
        lo_next = red;
        if (green < lo_next) lo_next = green;
        if (blue < lo_next) lo_next = blue;
        // red wins ties, then green
        if (red >= green && red >= blue) begin
            hi_next   = red;
            diff_next = $signed({1'b0, green}) - $signed({1'b0, blue});
            sec_next  = (green >= blue) ? SEC_RED_POS : SEC_RED_NEG;
        end else if (green >= blue) begin
            hi_next   = green;
            diff_next = $signed({1'b0, blue}) - $signed({1'b0, red});
            sec_next  = SEC_GREEN;
        end else begin
            hi_next   = blue;
            diff_next = $signed({1'b0, red}) - $signed({1'b0, green});
            sec_next  = SEC_BLUE;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hi_reg   <= hi_next;
            d_reg    <= hi_next - lo_next;
            diff_reg <= diff_next;
            sec_reg  <= sec_next;
        end
    end

    // hue dividend 2*num + d, with num = 120*k*d + 60*diff
    always_comb begin
        case (sec_reg)
            SEC_RED_POS: base = '0;
            SEC_GREEN:   base = DIVD_W'(d_reg) * DIVD_W'(240);
            SEC_BLUE:    base = DIVD_W'(d_reg) * DIVD_W'(480);
            SEC_RED_NEG: base = DIVD_W'(d_reg) * DIVD_W'(720);
            default:     base = '0;
        endcase
        diff_w  = HUE_ACC_W'(diff_reg);
        hue_acc = $signed({2'b00, base}) + diff_w * HUE_ACC_W'(120)
                + $signed({{(HUE_ACC_W-CHAN_W){1'b0}}, d_reg});
    end

    assign hue_x  = hue_acc[DIVD_W-1:0];
    assign sat_x  = DIVD_W'(d_reg) * DIVD_W'(510) + DIVD_W'(hi_reg);
    assign hi     = hi_reg;
    assign chroma = d_reg;

endmodule

### src/rhsv_divider.sv
// ----------------------------------------------------------------------------
// rhsv_divider
// Three-stage floor(x / 2d) by reciprocal multiply and one correction step.
// ----------------------------------------------------------------------------
module rhsv_divider
    import rhsv_pkg::*;
(
    input  logic                 aclk,
    input  div_ctrl_t            ctrl,
    input  logic [DIVD_W-1:0]    x_in,
    input  logic [CHAN_W-1:0]    d_in,
    output logic [QUOT_W-1:0]    q_out
);

    logic [DIVD_W-1:0]          x_a_reg, x_b_reg;
    logic [DIVS_W-1:0]          y_a_reg, y_b_reg;
    logic [RECIP_W-1:0]         r_a_reg;
    logic [QUOT_W-1:0]          q_b_reg, q_c_reg;

    logic [DIVD_W+RECIP_W-1:0]  prod;
    logic [DIVD_W-1:0]          back, rem;
    logic [QUOT_W-1:0]          q_c_next;

    always_ff @(posedge aclk) begin
        if (ctrl.en_a) begin
            x_a_reg <= x_in;
            y_a_reg <= {d_in, 1'b0};
            r_a_reg <= RECIP_TBL[d_in];
        end
    end

    assign prod = (DIVD_W + RECIP_W)'(x_a_reg) * (DIVD_W + RECIP_W)'(r_a_reg);

    always_ff @(posedge aclk) begin
        if (ctrl.en_b) begin
            x_b_reg <= x_a_reg;
            y_b_reg <= y_a_reg;
            q_b_reg <= prod[FRAC_W +: QUOT_W];
        end
    end

    // estimate is low by at most one
    always_comb begin
        back     = DIVD_W'(q_b_reg) * DIVD_W'(y_b_reg);
        rem      = x_b_reg - back;
        q_c_next = (rem >= DIVD_W'(y_b_reg)) ? q_b_reg + QUOT_W'(1) : q_b_reg;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en_c) begin
            q_c_reg <= q_c_next;
        end
    end

    assign q_out = q_c_reg;

endmodule

### src/rgb_to_hsv_pixel_converter_top.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_converter_top
// Streaming 8-bit RGB to HSV converter, hexcone rule, rounded to nearest.
// ----------------------------------------------------------------------------
// One pixel enters per clock while s_tready is high, and its result passes
// through the five register stages (sector, reciprocal lookup, multiply,
// correction, output). Throughput is one pixel per cycle whenever
// m_tready is high; a stall on the output side backs up through the stages
// and bubbles are squeezed out, so s_tready drops only when every stage holds
// a pixel. Hue and saturation each use their own reciprocal multiplier.
module rgb_to_hsv_pixel_converter_top
    import rhsv_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // blue[7:0], green[15:8], red[23:16]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata    // hue[8:0], saturation[16:9], brightness[24:17], zero
);

    logic [5:1]          valid_reg;
    logic [5:1]          en;

    logic [CHAN_W-1:0]   hi1, d1;
    logic [DIVD_W-1:0]   hue_x, sat_x;
    logic [QUOT_W-1:0]   hue_q, sat_q;
    div_ctrl_t           ctrl;

    logic [CHAN_W-1:0]   hi2_reg, hi3_reg, hi4_reg;
    logic                dz2_reg, dz3_reg, dz4_reg;

    logic [HUE_W-1:0]    hue_reg, hue_next;
    logic [CHAN_W-1:0]   sat_reg, sat_next;
    logic [CHAN_W-1:0]   bri_reg;

    // a stage advances when it is empty or its successor advances
    always_comb begin
        en[5] = !valid_reg[5] || m_tready;
        for (int k = 4; k >= 1; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (en[1]) valid_reg[1] <= s_tvalid;
            for (int k = 2; k <= 5; k++) begin
                if (en[k]) valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    assign ctrl.en_a = en[2];
    assign ctrl.en_b = en[3];
    assign ctrl.en_c = en[4];

    rhsv_sector u_sector (
        .aclk   (aclk),
        .en     (en[1]),
        .blue   (s_tdata[7:0]),
        .green  (s_tdata[15:8]),
        .red    (s_tdata[23:16]),
        .hi     (hi1),
        .chroma (d1),
        .hue_x  (hue_x),
        .sat_x  (sat_x)
    );

    rhsv_divider u_hue_div (
        .aclk  (aclk),
        .ctrl  (ctrl),
        .x_in  (hue_x),
        .d_in  (d1),
        .q_out (hue_q)
    );

    rhsv_divider u_sat_div (
        .aclk  (aclk),
        .ctrl  (ctrl),
        .x_in  (sat_x),
        .d_in  (hi1),
        .q_out (sat_q)
    );

    // carry brightness and the grey flag alongside the dividers
    always_ff @(posedge aclk) begin
        if (en[2]) begin
            hi2_reg <= hi1;
            dz2_reg <= (d1 == '0);
        end
        if (en[3]) begin
            hi3_reg <= hi2_reg;
            dz3_reg <= dz2_reg;
        end
        if (en[4]) begin
            hi4_reg <= hi3_reg;
            dz4_reg <= dz3_reg;
        end
    end

    // grey pixels get hue zero, black pixels saturation zero; drop 360 to 0
    always_comb begin
        hue_next = hue_q;
        if (dz4_reg || hue_q >= HUE_WRAP) hue_next = '0;
        sat_next = (hi4_reg == '0) ? '0 : sat_q[CHAN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            bri_reg <= hi4_reg;
        end
    end

    assign s_tready = en[1];
    assign m_tvalid = valid_reg[5];
    assign m_tdata  = {7'b0, bri_reg, sat_reg, hue_reg};

endmodule

### src/rhsv_checker.sv
// ----------------------------------------------------------------------------
// rhsv_checker
// Port-level checks on the converter's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module rhsv_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tready,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [31:0]  m_tdata
);

    // hold a stalled result transaction
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result transaction changed");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // with the output stage empty no stage can block the input
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while pipeline drains");

    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[8:0] < 9'd360) && (m_tdata[31:25] == 7'd0))
        else $error("hue out of range or padding set");

    a_black: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[24:17] == 8'd0) |->
            (m_tdata[16:9] == 8'd0) && (m_tdata[8:0] == 9'd0))
        else $error("black pixel with nonzero hue or saturation");

endmodule

bind rgb_to_hsv_pixel_converter_top rhsv_checker u_rhsv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/sv/rgb_to_hsv_pixel_converter_top_tb.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_converter_top_tb
// Self-checking bench for the streaming RGB to HSV pixel converter. Pixels
// go in through the input stream with random gaps and back pressure. Each
// accepted pixel is run through an integer hexcone predictor, and every
// result transaction is checked field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel_converter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rhsv_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int MAX_GAP     = 11;
    localparam int LATENCY     = 5;
    localparam int NUM_RANDOM  = 1600;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [CHAN_W-1:0] brightness;
        logic [CHAN_W-1:0] saturation;
        logic [HUE_W-1:0]  hue;
    } hsv_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // blue[7:0], green[15:8], red[23:16]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // hue[8:0], saturation[16:9], brightness[24:17], zero

    hsv_t hsv_pending[$];
    hsv_t hsv_head;
    hsv_t hsv_seen;
    int   mismatches  = 0;
    int   cycle_count = 0;
    int   sink_hold   = 0;
    bit   src_idle_en  = 1'b1;
    bit   sink_idle_en = 1'b1;

    rgb_to_hsv_pixel_converter_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #CLK_HALF aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // Rounded quotient, ties upward.
    function automatic int div_round(input int num, input int den);
        return (2 * num + den) / (2 * den);
    endfunction

    function automatic hsv_t convert_pixel(input pixel_t px);
        hsv_t res;
        int   r, g, b, hi, lo, d, num, hue;
        r  = px.red;
        g  = px.green;
        b  = px.blue;
        hi = r;
        lo = r;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        d   = hi - lo;
        hue = 0;
        if (d != 0) begin
            // Red wins ties for max, then green.
            if (hi == r)
                num = (g >= b) ? 60 * (g - b) : 360 * d - 60 * (b - g);
            else if (hi == g)
                num = 120 * d + 60 * b - 60 * r;
            else
                num = 240 * d + 60 * r - 60 * g;
            hue = div_round(num, d);
            if (hue >= 360) hue = 0;
        end
        res.hue        = HUE_W'(hue);
        res.saturation = (hi != 0) ? CHAN_W'(div_round(255 * d, hi)) : '0;
        res.brightness = CHAN_W'(hi);
        return res;
    endfunction

    task automatic send_pixel(input pixel_t px);
        int gap;
        gap = src_idle_en ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        hsv_pending.push_back(convert_pixel(px));
    endtask

    function automatic pixel_t random_pixel();
        pixel_t            px;
        logic [CHAN_W-1:0] v;
        px = 24'($urandom);
        v  = CHAN_W'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
            0: px = '{v, v, v};
            1: px.green = px.red;
            2: px.blue  = px.red;
            3: px.blue  = px.green;
            4: px = px & 24'h0f0f0f;
            default: ;
        endcase
        return px;
    endfunction

    task automatic report_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Result side: random stall per transaction, or a long hold when requested.
    initial begin : sink_proc
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (sink_hold > 0) begin
                stall     = sink_hold;
                sink_hold = 0;
            end else begin
                stall = sink_idle_en ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            hsv_seen = m_tdata[$bits(hsv_t)-1:0];
            if (hsv_pending.size() == 0) begin
                $display("%0t: result with nothing pending, expected none, got %h",
                         $time, m_tdata);
                mismatches++;
            end else begin
                hsv_head = hsv_pending.pop_front();
                report_field("hue", hsv_head.hue, hsv_seen.hue);
                report_field("saturation", hsv_head.saturation, hsv_seen.saturation);
                report_field("brightness", hsv_head.brightness, hsv_seen.brightness);
            end
        end
    end

    task automatic test_directed();
        pixel_t corners[$];
        corners = '{
            '{8'd0,   8'd0,   8'd0},     // black
            '{8'd255, 8'd255, 8'd255},   // white
            '{8'd128, 8'd128, 8'd128},   // mid grey
            '{8'd1,   8'd1,   8'd1},
            '{8'd255, 8'd0,   8'd0},     // pure red
            '{8'd0,   8'd255, 8'd0},     // pure green
            '{8'd0,   8'd0,   8'd255},   // pure blue
            '{8'd255, 8'd255, 8'd0},     // red and green tie, red sector
            '{8'd0,   8'd255, 8'd255},   // green and blue tie, green sector
            '{8'd255, 8'd0,   8'd255},   // red and blue tie, wraps below 360
            '{8'd255, 8'd0,   8'd1},     // rounds to 360, folds to 0
            '{8'd200, 8'd50,  8'd100},
            '{8'd120, 8'd1,   8'd0},     // hue half-way tie
            '{8'd2,   8'd1,   8'd1},     // saturation half-way tie
            '{8'd1,   8'd0,   8'd0},
            '{8'd0,   8'd1,   8'd0},
            '{8'd0,   8'd0,   8'd1},
            '{8'd10,  8'd200, 8'd90},
            '{8'd30,  8'd60,  8'd250},
            '{8'd254, 8'd255, 8'd0},
            '{8'd0,   8'd254, 8'd255}
        };
        foreach (corners[i]) send_pixel(corners[i]);
    endtask

    // Hold the result side long enough that the pipe fills and s_tready drops.
    task automatic test_back_pressure();
        src_idle_en = 1'b0;
        sink_hold   = HOLD_CYCLES;
        repeat (40) send_pixel(random_pixel());
        src_idle_en = 1'b1;
    endtask

    task automatic test_random();
        for (int i = 0; i < NUM_RANDOM; i++) begin
            if (i % 200 == 0) begin
                src_idle_en  = ($urandom_range(0, 3) != 0);
                sink_idle_en = ($urandom_range(0, 3) != 0);
            end
            send_pixel(random_pixel());
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_back_pressure();
        test_random();
        s_tvalid <= 1'b0;
        while (hsv_pending.size() != 0) @(posedge aclk);
        repeat (4 * LATENCY) @(posedge aclk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
